/* rtl/fdre_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fdre_pkg
// Shared types and constants of the frame delta run encoder.
// ----------------------------------------------------------------------------
package fdre_pkg;

    localparam int LEN_W     = 25;
    localparam int PIX_W     = 32;
    localparam int KIND_W    = 2;
    localparam int CMD_DEPTH = 4;

    localparam int MAX_RUN_DEF   = 32;
    localparam int MAX_FRAME_DEF = 16777216;

    typedef enum logic [KIND_W-1:0] {
        KIND_SUSTAIN = 2'd0,
        KIND_REFRESH = 2'd1,
        KIND_PIXEL   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HDR,
        BK_PIX
    } back_state_t;

    // one run to emit
    typedef struct packed {
        logic             is_refresh;
        logic             bank;
        logic [LEN_W-1:0] count;
        logic             burst_last;
        logic             frame_last;
    } cmd_t;

    // back end is done reading a buffer bank
    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

endpackage
`default_nettype wire

/* rtl/fdre_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fdre_front
// Classifies pixels, tracks the open run, buffers refresh pixels and issues
// run commands to the queue.
// ----------------------------------------------------------------------------
module fdre_front #(
    parameter int MAX_RUN          = fdre_pkg::MAX_RUN_DEF,
    parameter int MAX_FRAME_PIXELS = fdre_pkg::MAX_FRAME_DEF
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_wr_en,
    input  wire                                   cfg_wr_data,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire  [fdre_pkg::PIX_W-1:0]            previous_pixel,
    input  wire  [fdre_pkg::PIX_W-1:0]            current_pixel,
    input  wire                                   end_of_frame,
    input  wire                                   q_space,
    output logic                                  push_a,
    output fdre_pkg::cmd_t                        cmd_a,
    output logic                                  push_b,
    output fdre_pkg::cmd_t                        cmd_b,
    output logic                                  buf_we,
    output logic [((MAX_RUN > 1) ? $clog2(MAX_RUN) : 1):0] buf_addr,
    output logic [fdre_pkg::PIX_W-1:0]            buf_data,
    input  fdre_pkg::release_t                    rel
);

    localparam int IDXW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int LW   = fdre_pkg::LEN_W;
    localparam int RLIM = (MAX_FRAME_PIXELS < MAX_RUN) ? MAX_FRAME_PIXELS : MAX_RUN;

    logic          full_refresh_reg;
    logic          run_open_reg, run_open_next;
    logic          run_is_refresh_reg, run_is_refresh_next;
    logic [LW-1:0] run_count_reg, run_count_next;
    logic          wr_bank_reg, wr_bank_next;
    logic [1:0]    busy_reg, busy_next;

    logic          accept;
    logic          changed;
    logic          flush_a;
    logic          flush_b;
    logic          limit;
    logic          refresh_flush;
    logic [LW-1:0] base;
    logic [LW-1:0] cnt1;

    assign s_ready = q_space & ~busy_reg[wr_bank_reg];
    assign accept  = s_valid & s_ready;

    assign changed = full_refresh_reg | (previous_pixel != current_pixel);
    assign flush_a = run_open_reg & (run_is_refresh_reg != changed);
    assign base    = (flush_a | ~run_open_reg) ? '0 : run_count_reg;
    assign cnt1    = base + LW'(1);
    assign limit   = changed ? (cnt1 >= LW'(RLIM)) : (cnt1 >= LW'(MAX_FRAME_PIXELS));
    assign flush_b = limit | end_of_frame;

    assign push_a = accept & flush_a;
    assign push_b = accept & flush_b;

    always_comb begin
        cmd_a.is_refresh = run_is_refresh_reg;
        cmd_a.bank       = wr_bank_reg;
        cmd_a.count      = run_count_reg;
        cmd_a.burst_last = ~flush_b;
        cmd_a.frame_last = 1'b0;
        cmd_b.is_refresh = changed;
        cmd_b.bank       = wr_bank_reg;
        cmd_b.count      = cnt1;
        cmd_b.burst_last = 1'b1;
        cmd_b.frame_last = end_of_frame;
    end

    assign buf_we   = accept & changed;
    assign buf_addr = {wr_bank_reg, base[IDXW-1:0]};
    assign buf_data = current_pixel;

    assign refresh_flush = (push_a & run_is_refresh_reg) | (push_b & changed);

    always_comb begin
        wr_bank_next        = wr_bank_reg ^ refresh_flush;
        busy_next           = busy_reg;
        run_open_next       = run_open_reg;
        run_is_refresh_next = run_is_refresh_reg;
        run_count_next      = run_count_reg;
        if (rel.valid) begin
            busy_next[rel.bank] = 1'b0;
        end
        if (refresh_flush) begin
            busy_next[wr_bank_reg] = 1'b1;
        end
        if (accept) begin
            run_open_next       = ~flush_b;
            run_is_refresh_next = changed;
            run_count_next      = flush_b ? '0 : cnt1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_refresh_reg   <= 1'b0;
            run_open_reg       <= 1'b0;
            run_is_refresh_reg <= 1'b0;
            run_count_reg      <= '0;
            wr_bank_reg        <= 1'b0;
            busy_reg           <= '0;
        end else begin
            if (cfg_wr_en) begin
                full_refresh_reg <= cfg_wr_data;
            end
            run_open_reg       <= run_open_next;
            run_is_refresh_reg <= run_is_refresh_next;
            run_count_reg      <= run_count_next;
            wr_bank_reg        <= wr_bank_next;
            busy_reg           <= busy_next;
        end
    end

`ifndef SYNTH
    a_write_free_bank: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_we |-> !busy_reg[wr_bank_reg])
        else $error("refresh buffer write into a bank still being read");

    a_refresh_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_open_reg && run_is_refresh_reg) |-> (run_count_reg < LW'(RLIM)))
        else $error("open refresh run reached split length");
`endif

endmodule
`default_nettype wire

/* rtl/fdre_cmd_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fdre_cmd_fifo
// Short run command queue, up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module fdre_cmd_fifo (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             push_a,
    input  fdre_pkg::cmd_t  cmd_a,
    input  wire             push_b,
    input  fdre_pkg::cmd_t  cmd_b,
    output logic            space,
    output logic            q_valid,
    output fdre_pkg::cmd_t  q_data,
    input  wire             q_pop
);

    localparam int DEPTH = fdre_pkg::CMD_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    fdre_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    count_reg, count_next;
    logic [1:0]     n_push;
    logic           any_push;
    fdre_pkg::cmd_t first_cmd;

    assign any_push  = push_a | push_b;
    assign n_push    = {1'b0, push_a} + {1'b0, push_b};
    assign first_cmd = push_a ? cmd_a : cmd_b;

    assign space   = count_reg <= (PW+1)'(DEPTH - 2);
    assign q_valid = count_reg != '0;
    assign q_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(n_push);
        rd_ptr_next = rd_ptr_reg + PW'(q_pop);
        count_next  = count_reg + (PW+1)'(n_push) - (PW+1)'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (any_push) begin
            entry_reg[wr_ptr_reg] <= first_cmd;
        end
        if (push_a && push_b) begin
            entry_reg[wr_ptr_reg + PW'(1)] <= cmd_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PW+1)'(DEPTH))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("command queue pop while empty");
`endif

endmodule
`default_nettype wire

/* rtl/fdre_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fdre_back
// Holds the two-bank refresh buffer and turns run commands into headers and
// buffered pixel transfers, one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module fdre_back #(
    parameter int MAX_RUN = fdre_pkg::MAX_RUN_DEF
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   buf_we,
    input  wire  [((MAX_RUN > 1) ? $clog2(MAX_RUN) : 1):0] buf_addr,
    input  wire  [fdre_pkg::PIX_W-1:0]            buf_data,
    input  wire                                   q_valid,
    input  fdre_pkg::cmd_t                        q_data,
    output logic                                  q_pop,
    output fdre_pkg::release_t                    rel,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic [fdre_pkg::KIND_W-1:0]           m_kind,
    output logic [fdre_pkg::LEN_W-1:0]            m_len,
    output logic [fdre_pkg::PIX_W-1:0]            m_pix,
    output logic                                  m_burst_last,
    output logic                                  m_frame_last
);

    localparam int IDXW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int AW   = IDXW + 1;
    localparam int LW   = fdre_pkg::LEN_W;

    logic [fdre_pkg::PIX_W-1:0] buf_mem [2**AW];
    logic [fdre_pkg::PIX_W-1:0] rd_data_reg;

    fdre_pkg::back_state_t state_reg, state_next;
    fdre_pkg::cmd_t        cmd_reg, cmd_next;
    logic [IDXW-1:0]       idx_reg, idx_next;
    logic [IDXW-1:0]       last_idx;
    logic                  last_item;
    logic                  item_done;

    assign last_idx = cmd_reg.count[IDXW-1:0] - IDXW'(1);

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        case (state_reg)
            fdre_pkg::BK_IDLE: begin
            end
            fdre_pkg::BK_HDR: begin
                if (m_ready) begin
                    if (cmd_reg.is_refresh) begin
                        state_next = fdre_pkg::BK_PIX;
                        idx_next   = '0;
                    end else begin
                        state_next = fdre_pkg::BK_IDLE;
                    end
                end
            end
            fdre_pkg::BK_PIX: begin
                if (m_ready) begin
                    if (idx_reg == last_idx) begin
                        state_next = fdre_pkg::BK_IDLE;
                    end else begin
                        idx_next = idx_reg + IDXW'(1);
                    end
                end
            end
            default: begin
                state_next = fdre_pkg::BK_IDLE;
            end
        endcase
        if (q_pop) begin
            state_next = fdre_pkg::BK_HDR;
            cmd_next   = q_data;
            idx_next   = '0;
        end
    end

    always_comb begin
        m_valid      = 1'b0;
        m_kind       = fdre_pkg::KIND_PIXEL;
        m_len        = '0;
        m_pix        = '0;
        last_item    = 1'b0;
        case (state_reg)
            fdre_pkg::BK_IDLE: begin
            end
            fdre_pkg::BK_HDR: begin
                m_valid   = 1'b1;
                m_kind    = cmd_reg.is_refresh ? fdre_pkg::KIND_REFRESH
                                               : fdre_pkg::KIND_SUSTAIN;
                m_len     = cmd_reg.count;
                last_item = ~cmd_reg.is_refresh;
            end
            fdre_pkg::BK_PIX: begin
                m_valid   = 1'b1;
                m_pix     = rd_data_reg;
                last_item = idx_reg == last_idx;
            end
            default: begin
            end
        endcase
        m_burst_last = last_item & cmd_reg.burst_last;
        m_frame_last = last_item & cmd_reg.frame_last;
        item_done    = m_valid & m_ready & last_item;
        q_pop        = q_valid & ((state_reg == fdre_pkg::BK_IDLE) | item_done);
        rel.valid    = item_done & (state_reg == fdre_pkg::BK_PIX);
        rel.bank     = cmd_reg.bank;
    end

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[buf_addr] <= buf_data;
        end
        rd_data_reg <= buf_mem[{cmd_next.bank, idx_next}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fdre_pkg::BK_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
        cmd_reg <= cmd_next;
    end

`ifndef SYNTH
    a_pix_from_refresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fdre_pkg::BK_PIX) |-> cmd_reg.is_refresh)
        else $error("pixel transfer outside a refresh run");

    a_refresh_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fdre_pkg::BK_HDR && cmd_reg.is_refresh) |->
            (cmd_reg.count != '0 && cmd_reg.count <= LW'(MAX_RUN)))
        else $error("refresh run length out of range");
`endif

endmodule
`default_nettype wire

/* rtl/frame_delta_run_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// frame_delta_run_encoder
// Run encoder of frame differences: sustain and refresh runs per pixel pair.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one pixel position per transfer in raster order, previous
//   and current frame word; s_tlast marks the last pixel of a frame.
//   m_* carries run headers (with run length) and the buffered refresh pixel
//   words; m_tlast marks the last result caused by one input transfer and
//   m_tuser[2] the final result of a frame.
//   cfg_wr_en/cfg_wr_data set full_refresh; write it only while idle.
// Timing:
//   An input is taken every cycle while the run queue has room for two
//   commands and the refresh buffer bank it fills is free. The first result
//   of a run is output once its command has passed the queue and the back
//   end's command register. The output side moves one result per cycle
//   while m_tready is high; a refresh run of N pixels gives N+1 results, a
//   sustain run one, so output bandwidth sets the input rate on busy images.
// Reset: aresetn low clears the open run, the queue and full_refresh.
// A stalled receiver holds m_* steady; the input side keeps going until the
// queue lacks room for two commands or both buffer banks are full.
// ----------------------------------------------------------------------------
module frame_delta_run_encoder #(
    parameter int MAX_RUN          = fdre_pkg::MAX_RUN_DEF,
    parameter int MAX_FRAME_PIXELS = fdre_pkg::MAX_FRAME_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire         cfg_wr_data,     // full_refresh
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,         // previous_pixel, current_pixel
    input  wire         s_tlast,         // end_of_frame
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,         // run_length, pixel_value, zero pad
    output logic [2:0]  m_tuser,         // item_kind, frame_last
    output logic        m_tlast          // burst_last
);

    localparam int IDXW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    logic               push_a, push_b;
    fdre_pkg::cmd_t     cmd_a, cmd_b;
    logic               q_space, q_valid, q_pop;
    fdre_pkg::cmd_t     q_data;
    logic               buf_we;
    logic [IDXW:0]      buf_addr;
    logic [31:0]        buf_data;
    fdre_pkg::release_t rel;
    logic [1:0]         m_kind;
    logic [24:0]        m_len;
    logic [31:0]        m_pix;
    logic               m_frame_last;

    fdre_front #(
        .MAX_RUN          (MAX_RUN),
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_tvalid),
        .s_ready        (s_tready),
        .previous_pixel (s_tdata[31:0]),
        .current_pixel  (s_tdata[63:32]),
        .end_of_frame   (s_tlast),
        .q_space        (q_space),
        .push_a         (push_a),
        .cmd_a          (cmd_a),
        .push_b         (push_b),
        .cmd_b          (cmd_b),
        .buf_we         (buf_we),
        .buf_addr       (buf_addr),
        .buf_data       (buf_data),
        .rel            (rel)
    );

    fdre_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_a  (push_a),
        .cmd_a   (cmd_a),
        .push_b  (push_b),
        .cmd_b   (cmd_b),
        .space   (q_space),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    fdre_back #(
        .MAX_RUN (MAX_RUN)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .buf_we       (buf_we),
        .buf_addr     (buf_addr),
        .buf_data     (buf_data),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .rel          (rel),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_kind       (m_kind),
        .m_len        (m_len),
        .m_pix        (m_pix),
        .m_burst_last (m_tlast),
        .m_frame_last (m_frame_last)
    );

    assign m_tdata = {7'd0, m_pix, m_len};
    assign m_tuser = {m_frame_last, m_kind};

endmodule
`default_nettype wire

/* dv/frame_delta_run_checker.sv */
// ----------------------------------------------------------------------------
// frame_delta_run_checker
// Watches the pixel and result streams of the frame delta run encoder,
// forms the runs that each accepted pixel closes and compares every result
// transfer, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module frame_delta_run_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire         cfg_wr_data,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [63:0] s_tdata,
    input  wire         s_tlast,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [63:0] m_tdata,
    input  wire  [2:0]  m_tuser,
    input  wire         m_tlast,
    output int          mismatches,
    output int          outstanding
);

    localparam int RUN_CAP       = fdre_pkg::MAX_RUN_DEF;
    localparam int FRAME_CAP     = fdre_pkg::MAX_FRAME_DEF;
    localparam int REFRESH_LIMIT = (RUN_CAP < FRAME_CAP) ? RUN_CAP : FRAME_CAP;
    localparam int HELD_W        = (RUN_CAP > 1) ? $clog2(RUN_CAP) : 1;

    typedef struct {
        fdre_pkg::kind_t            kind;
        logic [fdre_pkg::LEN_W-1:0] run_length;
        logic [fdre_pkg::PIX_W-1:0] pixel_value;
        logic                       burst_last;
        logic                       frame_last;
    } run_result_t;

    run_result_t                owed_q[$];
    run_result_t                burst[$];
    run_result_t                want;
    run_result_t                tail;
    logic                       refresh_all;
    logic                       run_open;
    logic                       run_refresh;
    logic [fdre_pkg::LEN_W-1:0] run_len;
    logic [fdre_pkg::PIX_W-1:0] held_pixels [RUN_CAP];
    logic [fdre_pkg::PIX_W-1:0] prev_pix;
    logic [fdre_pkg::PIX_W-1:0] cur_pix;
    logic                       changed;
    int                         fail_total = 0;

    task automatic close_run();
        run_result_t r;
        if (!run_open)
            return;
        r.burst_last  = 1'b0;
        r.frame_last  = 1'b0;
        r.pixel_value = '0;
        r.run_length  = run_len;
        r.kind        = run_refresh ? fdre_pkg::KIND_REFRESH : fdre_pkg::KIND_SUSTAIN;
        burst.push_back(r);
        if (run_refresh) begin
            for (int i = 0; i < run_len && i < RUN_CAP; i++) begin
                r.kind        = fdre_pkg::KIND_PIXEL;
                r.run_length  = '0;
                r.pixel_value = held_pixels[HELD_W'(i)];
                burst.push_back(r);
            end
        end
        run_open    = 1'b0;
        run_refresh = 1'b0;
        run_len     = '0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            refresh_all = 1'b0;
            run_open    = 1'b0;
            run_refresh = 1'b0;
            run_len     = '0;
            owed_q.delete();
        end else begin
            if (cfg_wr_en)
                refresh_all = cfg_wr_data;

            if (s_tvalid && s_tready) begin
                prev_pix = s_tdata[31:0];
                cur_pix  = s_tdata[63:32];
                changed  = refresh_all || (prev_pix != cur_pix);
                burst.delete();
                if (run_open && run_refresh != changed)
                    close_run();
                if (!run_open) begin
                    run_open    = 1'b1;
                    run_refresh = changed;
                    run_len     = '0;
                end
                if (changed) begin
                    if (run_len < RUN_CAP)
                        held_pixels[run_len[HELD_W-1:0]] = cur_pix;
                    run_len = run_len + 1'b1;
                    if (run_len >= REFRESH_LIMIT)
                        close_run();
                end else begin
                    run_len = run_len + 1'b1;
                    if (run_len >= FRAME_CAP)
                        close_run();
                end
                if (s_tlast)
                    close_run();
                if (burst.size() > 0) begin
                    tail            = burst[burst.size()-1];
                    tail.burst_last = 1'b1;
                    tail.frame_last = s_tlast;
                    burst[burst.size()-1] = tail;
                end
                foreach (burst[i])
                    owed_q.push_back(burst[i]);
            end

            if (m_tvalid && m_tready) begin
                if (owed_q.size() == 0) begin
                    $error("result transfer with nothing owed: kind %0d length %0d",
                           m_tuser[1:0], m_tdata[24:0]);
                    fail_total++;
                end else begin
                    want = owed_q.pop_front();
                    if (m_tuser[1:0] !== want.kind) begin
                        $error("item_kind: expected %0d, got %0d", want.kind, m_tuser[1:0]);
                        fail_total++;
                    end
                    if (m_tdata[24:0] !== want.run_length) begin
                        $error("run_length: expected %0d, got %0d",
                               want.run_length, m_tdata[24:0]);
                        fail_total++;
                    end
                    if (m_tdata[56:25] !== want.pixel_value) begin
                        $error("pixel_value: expected %h, got %h",
                               want.pixel_value, m_tdata[56:25]);
                        fail_total++;
                    end
                    if (m_tdata[63:57] !== 7'd0) begin
                        $error("tdata pad: expected 0, got %h", m_tdata[63:57]);
                        fail_total++;
                    end
                    if (m_tlast !== want.burst_last) begin
                        $error("burst_last: expected %0d, got %0d", want.burst_last, m_tlast);
                        fail_total++;
                    end
                    if (m_tuser[2] !== want.frame_last) begin
                        $error("frame_last: expected %0d, got %0d", want.frame_last, m_tuser[2]);
                        fail_total++;
                    end
                end
            end
        end
        mismatches  <= fail_total;
        outstanding <= owed_q.size();
    end

endmodule

/* dv/frame_delta_run_encoder_test.sv */
// ----------------------------------------------------------------------------
// frame_delta_run_encoder_test
// Drives pixel pairs into the frame delta run encoder: a directed opening
// with word extremes, kind changes and full refresh, then random runs of
// changed and unchanged pixels in frames of random length, with random
// stalls on both streams. A separate checker owns prediction and compare.
// ----------------------------------------------------------------------------
module frame_delta_run_encoder_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SEG_ITEMS   = 70;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic [63:0] s_tdata     = '0;
    logic        s_tlast     = 1'b0;
    logic        m_tready    = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          mismatches;
    int          outstanding;
    int          cycles        = 0;
    int          send_idle_pct = 38;
    int          recv_idle_pct = 82;

    frame_delta_run_encoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    frame_delta_run_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send_pixel(input logic [31:0] prev, input logic [31:0] cur,
                              input logic eof);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cur, prev};
        s_tlast  <= eof;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_refresh(input logic value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        logic [31:0] prev;
        logic [31:0] cur;
        logic        run_changed;
        int          run_left;
        int          frame_left;
        int          pick;
        logic        refresh_plan [6];

        refresh_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        run_left     = 0;
        frame_left   = 0;
        run_changed  = 1'b0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        write_refresh(1'b0);

        // one-pixel sustain frame, then word extremes and kind changes
        send_pixel(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_pixel(32'h0000_0001, 32'h0000_0000, 1'b0);
        send_pixel(32'h8000_0000, 32'h0000_0000, 1'b1);
        send_pixel(32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1);
        send_pixel(32'h1234_5678, 32'h1234_5678, 1'b0);
        send_pixel(32'h1234_5678, 32'h1234_5678, 1'b0);
        send_pixel(32'h0000_0000, 32'h0000_0001, 1'b0);
        // refresh run closed and sustain pixel flushed in the same step
        send_pixel(32'h0000_0007, 32'h0000_0007, 1'b1);

        write_refresh(1'b1);
        send_pixel(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_pixel(32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b1);

        for (int seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin
                    send_idle_pct = 38;
                    recv_idle_pct = 82;
                end
                1: begin
                    send_idle_pct = 82;
                    recv_idle_pct = 38;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_refresh(refresh_plan[seg]);
            for (int k = 0; k < SEG_ITEMS; k++) begin
                if (frame_left == 0)
                    frame_left = ($urandom_range(9) == 0) ? $urandom_range(200, 80)
                                                          : $urandom_range(60, 1);
                if (run_left == 0) begin
                    run_changed = 1'($urandom_range(1));
                    pick        = $urandom_range(99);
                    if (pick < 60)
                        run_left = $urandom_range(4, 1);
                    else if (pick < 85)
                        run_left = $urandom_range(31, 5);
                    else
                        run_left = $urandom_range(70, 32);
                end
                prev = $urandom;
                if (!run_changed) begin
                    cur = prev;
                end else if ($urandom_range(1) == 1) begin
                    cur = prev ^ (32'd1 << $urandom_range(31));
                end else begin
                    cur = $urandom;
                    if (cur == prev)
                        cur = ~prev;
                end
                send_pixel(prev, cur, frame_left == 1);
                frame_left--;
                run_left--;
            end
        end

        settle();
        repeat (20) @(negedge aclk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
